// ----- sv/spq_pkg.sv -----
// Shared types, sizes and helpers for the sorted priority queue.
// No dependencies; imported by spq_entry_ram and sorted_priority_queue_core.
package spq_pkg;

  localparam int unsigned Depth = 16;                 // entries held, 2..64
  localparam int unsigned AddrW = $clog2(Depth);      // entry address
  localparam int unsigned CntW  = $clog2(Depth + 1);  // count 0..Depth

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_RM_HEAD,
    S_RM_SHIFT,
    S_LIST
  } state_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] key;
    logic [63:0]        payload;
  } spq_in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] out_key;
    logic [63:0]        out_payload;
    logic [4:0]         position;
    logic [4:0]         occupancy;
    logic               last;
  } spq_out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        payload;
  } spq_entry_t;

  // Counts and positions are reported modulo 32.
  function automatic logic [4:0] to_5b(input logic [CntW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[4:0];
  endfunction

endpackage

// ----- sv/sorted_priority_queue_core.sv -----
// Sorted priority queue core: sequencer, count and result register.
// Depends on spq_pkg and spq_entry_ram.
//
// Usage: drive item_i and raise start_i; the beat is taken at an edge where
// busy_o is low. busy_o stays high while the sequencer walks the store.
// Each result beat is on result_o for one cycle with result_valid_o high;
// the receiver cannot stall, so it must take every beat as it comes.
// Entries sit in a single-port-write RAM in ascending key order; one compare
// unit and one read/write per cycle do all the work.
// Steps per item (busy_o falls as the result strobe rises):
//   clear, insert into full, remove/list on empty: answered from idle
//   insert: walk down from the tail, moving each stored key greater than
//           the new key up one slot, then write the new key
//   remove: head read, then shift every entry down one
//   list:   results stream one per cycle
// The registered RAM read is overlapped with the shift loops: each read is
// issued while the entry read before it is written. Reset empties the queue
// (count to zero); RAM contents are left as they are and never read unless written.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  spq_in_t  item_i,
  output logic     result_valid_o,
  output spq_out_t result_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;     // walk pointer, 0..Depth
  spq_in_t         item_q, item_d;   // captured request
  spq_entry_t      head_q, head_d;   // entry taken by remove
  spq_out_t        res_q, res_d;
  logic            res_valid_q, res_valid_d;

  // RAM port signals
  logic             we;
  logic [AddrW-1:0] waddr;
  spq_entry_t       wdata;
  logic [AddrW-1:0] raddr;
  spq_entry_t       rdata;

  // Single compare unit, used by insert: stored key strictly above the new one moves up.
  logic            rd_greater;
  logic [CntW-1:0] idx_m1, idx_m2, idx_p1, cnt_m1;

  assign rd_greater = rdata.key > item_q.key;
  assign idx_m1     = idx_q - CntW'(1);
  assign idx_m2     = idx_q - CntW'(2);
  assign idx_p1     = idx_q + CntW'(1);
  assign cnt_m1     = count_q - CntW'(1);

  spq_entry_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    item_q <= item_d;
    head_q <= head_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    item_d      = item_q;
    head_d      = head_q;
    res_valid_d = 1'b0;
    res_d       = '{status: STAT_OK, out_key: '0, out_payload: '0,
                    position: '0, occupancy: to_5b(count_q), last: 1'b1};
    we          = 1'b0;
    waddr       = idx_q[AddrW-1:0];
    wdata       = rdata;
    raddr       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d = item_i;
          unique case (item_i.op)
            OP_INSERT: begin
              if (count_q == CntW'(Depth)) begin
                res_valid_d  = 1'b1;
                res_d.status = STAT_FULL;
              end else if (count_q == '0) begin
                idx_d   = '0;
                state_d = S_INS_PUT;
              end else begin
                idx_d   = count_q;
                raddr   = cnt_m1[AddrW-1:0];
                state_d = S_INS_CMP;
              end
            end
            OP_REMOVE: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                raddr   = '0;
                state_d = S_RM_HEAD;
              end
            end
            OP_CLEAR: begin
              count_d         = '0;
              res_valid_d     = 1'b1;
              res_d.occupancy = '0;
            end
            OP_LIST: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                idx_d   = '0;
                raddr   = '0;
                state_d = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      // rdata holds entry idx-1; move it up or drop the new entry at idx.
      S_INS_CMP: begin
        we = 1'b1;
        if (rd_greater) begin
          wdata = rdata;
          idx_d = idx_m1;
          if (idx_m1 == '0) begin
            state_d = S_INS_PUT;
          end else begin
            raddr = idx_m2[AddrW-1:0];
          end
        end else begin
          wdata           = '{key: item_q.key, payload: item_q.payload};
          count_d         = count_q + CntW'(1);
          res_valid_d     = 1'b1;
          res_d.occupancy = to_5b(count_d);
          state_d         = S_IDLE;
        end
      end

      // New key is the smallest: write it at the head.
      S_INS_PUT: begin
        we              = 1'b1;
        wdata           = '{key: item_q.key, payload: item_q.payload};
        count_d         = count_q + CntW'(1);
        res_valid_d     = 1'b1;
        res_d.occupancy = to_5b(count_d);
        state_d         = S_IDLE;
      end

      // rdata holds the head entry.
      S_RM_HEAD: begin
        head_d = rdata;
        if (count_q == CntW'(1)) begin
          count_d           = '0;
          res_valid_d       = 1'b1;
          res_d.out_key     = rdata.key;
          res_d.out_payload = rdata.payload;
          res_d.occupancy   = '0;
          state_d           = S_IDLE;
        end else begin
          idx_d   = CntW'(1);
          raddr   = AddrW'(1);
          state_d = S_RM_SHIFT;
        end
      end

      // rdata holds entry idx; write it one slot lower.
      S_RM_SHIFT: begin
        we    = 1'b1;
        waddr = idx_m1[AddrW-1:0];
        wdata = rdata;
        if (idx_q == cnt_m1) begin
          count_d           = cnt_m1;
          res_valid_d       = 1'b1;
          res_d.out_key     = head_q.key;
          res_d.out_payload = head_q.payload;
          res_d.occupancy   = to_5b(cnt_m1);
          state_d           = S_IDLE;
        end else begin
          idx_d = idx_p1;
          raddr = idx_p1[AddrW-1:0];
        end
      end

      // One beat per entry, rdata holds entry idx.
      S_LIST: begin
        res_valid_d       = 1'b1;
        res_d.out_key     = rdata.key;
        res_d.out_payload = rdata.payload;
        res_d.position    = to_5b(idx_p1);
        res_d.last        = (idx_q == cnt_m1);
        if (idx_q == cnt_m1) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_p1;
          raddr = idx_p1[AddrW-1:0];
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ----- sv/spq_entry_ram.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on spq_pkg for the entry type and depth.
module spq_entry_ram
  import spq_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  spq_entry_t       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output spq_entry_t       rdata_o
);

  spq_entry_t mem [Depth];
  spq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
